>>> hdl/hsl_pkg.sv
// shared types, constants and widths for the hsl to rgb565 converter
`default_nettype none
package hsl_pkg;

    // field widths
    localparam int HUE_W   = 15;
    localparam int Q12_W   = 13;
    localparam int WGT_W   = 12;
    localparam int RGB_W   = 16;

    // value limits
    localparam int HUE_MAX = 23039;
    localparam int Q12_ONE = 4096;
    localparam int SEXTANT = 3840;

    // divide by 3840: shift out 256, then multiply by the reciprocal of 15
    localparam int DIV_PRE_SHIFT = 8;
    localparam int RECIP_K       = 69906;
    localparam int RECIP_SHIFT   = 20;

    // channel packing
    localparam int RED_SHIFT = 11;
    localparam int GRN_SHIFT = 5;
    localparam int SUM_FRAC  = 13;

    // queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // hue sextant, named by the channels that get chroma and secondary term
    typedef enum logic [2:0] {
        SEXT_RC_GX = 3'd0,
        SEXT_RX_GC = 3'd1,
        SEXT_GC_BX = 3'd2,
        SEXT_GX_BC = 3'd3,
        SEXT_RX_BC = 3'd4,
        SEXT_RC_BX = 3'd5
    } t_sextant;

    // classified item as it waits in the queue
    typedef struct packed {
        logic [Q12_W-1:0] chroma_a;   // 1 - |2L - 1| in Q12
        logic [Q12_W-1:0] sat;
        logic [Q12_W-1:0] light;
        logic [WGT_W-1:0] weight;     // 3840 - |t - 3840|
        t_sextant         sext;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

>>> hdl/hsl_if.sv
// stream interfaces for hsl input beats and rgb565 output beats
`default_nettype none
interface hsl_in_if;
    logic        valid;
    logic        ready;
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [12:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface hsl_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rgb565;

    modport source (output valid, output rgb565, input ready);
    modport sink   (input valid, input rgb565, output ready);
endinterface
`default_nettype wire

>>> hdl/hsl_front.sv
// front end: accepts hsl beats, clamps them and classifies the hue sextant
`default_nettype none
module hsl_front (
    hsl_in_if.sink            i_pix,
    input  hsl_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output hsl_pkg::t_job     o_job
);
    import hsl_pkg::*;

    logic [HUE_W-1:0]   h;
    logic [Q12_W-1:0]   s;
    logic [Q12_W-1:0]   l;
    logic [Q12_W:0]     l2;
    logic [Q12_W:0]     span;
    logic [HUE_W-1:0]   base;
    logic [Q12_W-1:0]   t;
    logic [WGT_W-1:0]   d;
    t_sextant           sext;

    // accept whenever the queue has room
    assign i_pix.ready = !i_q_stat.full;
    assign o_push      = i_pix.valid && !i_q_stat.full;

    // clamp the inputs to their ranges
    always_comb begin
        h = (i_pix.hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : i_pix.hue;
        s = (i_pix.saturation > Q12_W'(Q12_ONE)) ? Q12_W'(Q12_ONE) : i_pix.saturation;
        l = (i_pix.lightness > Q12_W'(Q12_ONE)) ? Q12_W'(Q12_ONE) : i_pix.lightness;
    end

    // lightness distance from one half
    always_comb begin
        l2 = {l, 1'b0};
        if (l2 >= (Q12_W+1)'(Q12_ONE)) begin
            span = l2 - (Q12_W+1)'(Q12_ONE);
        end else begin
            span = (Q12_W+1)'(Q12_ONE) - l2;
        end
    end

    // sextant and start of its 120 degree pair
    always_comb begin
        if (h < HUE_W'(SEXTANT)) begin
            sext = SEXT_RC_GX;
            base = '0;
        end else if (h < HUE_W'(2*SEXTANT)) begin
            sext = SEXT_RX_GC;
            base = '0;
        end else if (h < HUE_W'(3*SEXTANT)) begin
            sext = SEXT_GC_BX;
            base = HUE_W'(2*SEXTANT);
        end else if (h < HUE_W'(4*SEXTANT)) begin
            sext = SEXT_GX_BC;
            base = HUE_W'(2*SEXTANT);
        end else if (h < HUE_W'(5*SEXTANT)) begin
            sext = SEXT_RX_BC;
            base = HUE_W'(4*SEXTANT);
        end else begin
            sext = SEXT_RC_BX;
            base = HUE_W'(4*SEXTANT);
        end
    end

    // phase within the pair and its distance from the middle
    always_comb begin
        t = Q12_W'(h - base);
        if (t >= Q12_W'(SEXTANT)) begin
            d = WGT_W'(t - Q12_W'(SEXTANT));
        end else begin
            d = WGT_W'(Q12_W'(SEXTANT) - t);
        end
    end

    // classified job
    always_comb begin
        o_job.chroma_a = Q12_W'((Q12_W+1)'(Q12_ONE) - span);
        o_job.sat      = s;
        o_job.light    = l;
        o_job.weight   = WGT_W'(SEXTANT) - d;
        o_job.sext     = sext;
    end

endmodule
`default_nettype wire

>>> hdl/hsl_queue.sv
// short job queue between the front and back ends
`default_nettype none
module hsl_queue #(
    parameter int DEPTH = hsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hsl_pkg::t_job     i_job,
    input  logic              i_pop,
    output hsl_pkg::t_job     o_job,
    output hsl_pkg::t_q_stat  o_q_stat
);
    import hsl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job              = r_mem[r_rd];
    assign o_q_stat.not_empty = (r_cnt != '0);
    assign o_q_stat.full      = (r_cnt == CNT_W'(DEPTH));

endmodule
`default_nettype wire

>>> hdl/hsl_back.sv
// back end: chroma, secondary term and channel scaling in a four stage pipe
`default_nettype none
module hsl_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hsl_pkg::t_job     i_job,
    input  hsl_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    hsl_out_if.source         o_pix
);
    import hsl_pkg::*;

    localparam int PROD_W = 2 * Q12_W;
    localparam int P2_W   = Q12_W + WGT_W;
    localparam int QUO_W  = 16;
    localparam int RCP_W  = 17;
    localparam int M2_W   = Q12_W + 1;
    localparam int SUM_W  = Q12_W + 2;
    localparam int SCL_W  = SUM_W + 6;

    logic                  en;
    logic [PROD_W-1:0]     prod_cs;
    logic [QUO_W-1:0]      quo;
    logic [QUO_W+RCP_W-1:0] prod_rcp;

    // stage 1: chroma
    logic                  r_v1;
    logic [Q12_W-1:0]      r_c1;
    logic [WGT_W-1:0]      r_w1;
    logic [Q12_W-1:0]      r_l1;
    t_sextant              r_s1;
    // stage 2: chroma times weight
    logic                  r_v2;
    logic [P2_W-1:0]       r_p2;
    logic [Q12_W-1:0]      r_c2;
    logic [Q12_W-1:0]      r_l2;
    t_sextant              r_s2;
    // stage 3: secondary term and offset
    logic                  r_v3;
    logic [Q12_W-1:0]      r_x3;
    logic [Q12_W-1:0]      r_c3;
    logic [M2_W-1:0]       r_m3;
    t_sextant              r_s3;
    // stage 4: packed output
    logic                  r_v4;
    logic [RGB_W-1:0]      r_out;

    logic [Q12_W-1:0]      comp_r, comp_g, comp_b;
    logic [SUM_W-1:0]      sum_r, sum_g, sum_b;
    logic [SCL_W-1:0]      scl_r, scl_g, scl_b;
    logic [4:0]            ch_r, ch_b;
    logic [5:0]            ch_g;

    // whole pipe advances unless the output beat is stalled
    assign en    = !r_v4 || o_pix.ready;
    assign o_pop = en && i_q_stat.not_empty;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_q_stat.not_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // chroma product and divide by 3840 via reciprocal
    assign prod_cs  = i_job.chroma_a * i_job.sat;
    assign quo      = r_p2[DIV_PRE_SHIFT +: QUO_W];
    assign prod_rcp = quo * RCP_W'(RECIP_K);

    // component order per sextant
    always_comb begin
        comp_r = '0;
        comp_g = '0;
        comp_b = '0;
        case (r_s3)
            SEXT_RC_GX: begin
                comp_r = r_c3;
                comp_g = r_x3;
            end
            SEXT_RX_GC: begin
                comp_r = r_x3;
                comp_g = r_c3;
            end
            SEXT_GC_BX: begin
                comp_g = r_c3;
                comp_b = r_x3;
            end
            SEXT_GX_BC: begin
                comp_g = r_x3;
                comp_b = r_c3;
            end
            SEXT_RX_BC: begin
                comp_r = r_x3;
                comp_b = r_c3;
            end
            SEXT_RC_BX: begin
                comp_r = r_c3;
                comp_b = r_x3;
            end
            default: begin
                comp_r = '0;
            end
        endcase
    end

    // add offset in q13, scale by 31 or 63 with shift and subtract
    always_comb begin
        sum_r = {1'b0, comp_r, 1'b0} + SUM_W'(r_m3);
        sum_g = {1'b0, comp_g, 1'b0} + SUM_W'(r_m3);
        sum_b = {1'b0, comp_b, 1'b0} + SUM_W'(r_m3);
        scl_r = (SCL_W'(sum_r) << 5) - SCL_W'(sum_r);
        scl_g = (SCL_W'(sum_g) << 6) - SCL_W'(sum_g);
        scl_b = (SCL_W'(sum_b) << 5) - SCL_W'(sum_b);
        ch_r  = scl_r[SUM_FRAC +: 5];
        ch_g  = scl_g[SUM_FRAC +: 6];
        ch_b  = scl_b[SUM_FRAC +: 5];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c1  <= prod_cs[Q12_W-1 +: Q12_W];
            r_w1  <= i_job.weight;
            r_l1  <= i_job.light;
            r_s1  <= i_job.sext;

            r_p2  <= r_c1 * r_w1;
            r_c2  <= r_c1;
            r_l2  <= r_l1;
            r_s2  <= r_s1;

            r_x3  <= prod_rcp[RECIP_SHIFT +: Q12_W];
            r_c3  <= r_c2;
            r_m3  <= {r_l2, 1'b0} - M2_W'(r_c2);
            r_s3  <= r_s2;

            r_out <= {ch_r, ch_g, ch_b};
        end
    end

    assign o_pix.valid  = r_v4;
    assign o_pix.rgb565 = r_out;

endmodule
`default_nettype wire

>>> hdl/hsl_to_rgb565.sv
// top level of the hsl to rgb565 converter: front, queue and back end
//
//  channel  dir  fields                           beat taken when
//  i_pix    in   hue, saturation, lightness       i_pix.valid && i_pix.ready
//  o_pix    out  rgb565                           o_pix.valid && o_pix.ready
//
// one beat per clock sustained while the output is not stalled; a taken beat
// passes through the queue and four back end stages: chroma multiply, weight
// multiply, reciprocal divide by 3840, channel scaling into the output register
// reset clears the queue pointers and count and the pipe valid bits only; no clearing pass
// an output stall freezes the back end; the queue fills up to QUEUE_DEPTH beats
// and then drops i_pix.ready
`default_nettype none
module hsl_to_rgb565 #(
    parameter int QUEUE_DEPTH = hsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsl_in_if.sink     i_pix,
    hsl_out_if.source  o_pix
);
    import hsl_pkg::*;

    logic     push;
    logic     pop;
    t_job     job_in;
    t_job     job_out;
    t_q_stat  q_stat;

    // classify incoming beats
    hsl_front u_front (
        .i_pix    (i_pix),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (job_in)
    );

    // decouple front and back
    hsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_job    (job_out),
        .o_q_stat (q_stat)
    );

    // compute and pack
    hsl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_pix    (o_pix)
    );

    // no beat taken into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |-> !q_stat.full)
        else $error("input beat taken while queue full");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.not_empty)
        else $error("queue popped while empty");

    // reset leaves no output beat pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");

    // a stalled back end holds its result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |=> (o_pix.valid && $stable(o_pix.rgb565)))
        else $error("output result changed during stall");

endmodule
`default_nettype wire

>>> sim/hsl_to_rgb565_chk.sv
// beat checker for the hsl to rgb565 converter: predicts each colour word and compares
`timescale 1ns / 100ps
module hsl_to_rgb565_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [14:0] i_hue,
    input  logic [12:0] i_saturation,
    input  logic [12:0] i_lightness,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_rgb565,
    output int          o_fail_cnt,
    output int          o_pending,
    output int          o_beats_in,
    output int          o_beats_out
);
    import hsl_pkg::*;

    localparam int unsigned RB_FULL  = 31;
    localparam int unsigned GRN_FULL = 63;
    localparam int          MAX_LOGGED = 40;

    logic [15:0] rgb_expect_q[$];
    int          fail_cnt;
    int          beats_in;
    int          beats_out;

    // expected packed colour for one hsl beat
    function automatic logic [15:0] rgb565_of_hsl(input logic [14:0] hue_in,
                                                  input logic [12:0] sat_in,
                                                  input logic [12:0] light_in);
        int unsigned h, s, l;
        int unsigned span, chroma, phase, dev, second, m2;
        int unsigned rc, gc, bc;
        t_sextant    sext;
        logic [4:0]  red, blue;
        logic [5:0]  green;
        // clamp out of range fields
        h = (hue_in > HUE_MAX) ? HUE_MAX : hue_in;
        s = (sat_in > Q12_ONE) ? Q12_ONE : sat_in;
        l = (light_in > Q12_ONE) ? Q12_ONE : light_in;
        // chroma from distance of 2l to one
        span   = (2 * l >= Q12_ONE) ? (2 * l - Q12_ONE) : (Q12_ONE - 2 * l);
        chroma = ((Q12_ONE - span) * s) >> 12;
        // secondary term from hue modulo 120 degrees
        phase  = h % (2 * SEXTANT);
        dev    = (phase >= SEXTANT) ? (phase - SEXTANT) : (SEXTANT - phase);
        second = (chroma * (SEXTANT - dev)) / SEXTANT;
        // offset m doubled, in q13
        m2     = 2 * l - chroma;
        // component order per sextant
        sext = t_sextant'(h / SEXTANT);
        rc = 0;
        gc = 0;
        bc = 0;
        case (sext)
            SEXT_RC_GX: begin rc = chroma; gc = second; end
            SEXT_RX_GC: begin rc = second; gc = chroma; end
            SEXT_GC_BX: begin gc = chroma; bc = second; end
            SEXT_GX_BC: begin gc = second; bc = chroma; end
            SEXT_RX_BC: begin rc = second; bc = chroma; end
            default:    begin rc = chroma; bc = second; end
        endcase
        // scale and pack
        red   = 5'(((2 * rc + m2) * RB_FULL) >> SUM_FRAC);
        green = 6'(((2 * gc + m2) * GRN_FULL) >> SUM_FRAC);
        blue  = 5'(((2 * bc + m2) * RB_FULL) >> SUM_FRAC);
        return {red, green, blue};
    endfunction

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what);
        if (fail_cnt < MAX_LOGGED) begin
            $display("mismatch at %0t: %s", $time, what);
        end
        fail_cnt++;
    endtask

    initial begin
        fail_cnt  = 0;
        beats_in  = 0;
        beats_out = 0;
    end

    // watch both channels at every edge
    always @(posedge i_clk) begin
        logic [15:0] want;
        if (i_rst_n) begin
            // input beat: queue its colour
            if (i_in_valid && i_in_ready) begin
                rgb_expect_q.push_back(rgb565_of_hsl(i_hue, i_saturation, i_lightness));
                beats_in++;
            end
            // output beat: compare with the oldest colour
            if (i_out_valid && i_out_ready) begin
                beats_out++;
                if (rgb_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat rgb565=%04h", i_rgb565));
                end else begin
                    want = rgb_expect_q.pop_front();
                    if (i_rgb565 !== want) begin
                        report_mismatch($sformatf(
                            "rgb565 got %04h (r%0d g%0d b%0d) want %04h (r%0d g%0d b%0d)",
                            i_rgb565, i_rgb565[15:11], i_rgb565[10:5], i_rgb565[4:0],
                            want, want[15:11], want[10:5], want[4:0]));
                    end
                end
            end
        end
        o_fail_cnt  <= fail_cnt;
        o_pending   <= rgb_expect_q.size();
        o_beats_in  <= beats_in;
        o_beats_out <= beats_out;
    end

endmodule

>>> sim/tb.sv
// top of the hsl to rgb565 testbench: clock, reset, beat stimulus and verdict
`timescale 1ns / 100ps
module tb;
    import hsl_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BEATS  = 240;
    localparam int HOLD_BEATS   = 60;
    localparam int TAIL_CYCLES  = 20;
    localparam int DIR_N        = 25;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   hold_req;
    int   hold_done;
    int   cycle_cnt;
    int   fail_cnt;
    int   pending;
    int   beats_in;
    int   beats_out;

    // directed beats: sextant middles and edges, clamps, extremes
    int unsigned dir_hue [DIR_N] = '{0, 1920, 5760, 9600, 13440, 17280, 21120, 3839, 3840,
                                     7679, 7680, 11520, 15360, 19200, 23039, 23040, 32767,
                                     0, 0, 0, 0, 1000, 1000, 4000, 20000};
    int unsigned dir_sat [DIR_N] = '{4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                                     4096, 4096, 4096, 4096, 4096, 4096, 4096, 8191,
                                     0, 0, 4096, 4096, 4097, 2048, 1, 8191};
    int unsigned dir_lit [DIR_N] = '{2048, 2048, 2048, 2048, 2048, 2048, 2048, 2048, 2048,
                                     2048, 2048, 2048, 2048, 2048, 2048, 2048, 8191,
                                     0, 4096, 0, 4096, 2048, 4097, 1, 3000};

    hsl_in_if  pix_in ();
    hsl_out_if pix_out ();

    hsl_to_rgb565 u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    hsl_to_rgb565_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (pix_in.valid),
        .i_in_ready   (pix_in.ready),
        .i_hue        (pix_in.hue),
        .i_saturation (pix_in.saturation),
        .i_lightness  (pix_in.lightness),
        .i_out_valid  (pix_out.valid),
        .i_out_ready  (pix_out.ready),
        .i_rgb565     (pix_out.rgb565),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pending),
        .o_beats_in   (beats_in),
        .o_beats_out  (beats_out)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("timeout after %0d cycles, %0d colours outstanding", cycle_cnt, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // output ready: random stalls, or a long hold-off on request
    initial begin
        pix_out.ready = 1'b0;
        hold_done     = 0;
        forever begin
            @(posedge clk);
            if (hold_req != hold_done) begin
                pix_out.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = hold_req;
            end else begin
                pix_out.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // random hue: mostly in range, some near sextant edges, some any 15-bit value
    function automatic logic [14:0] rand_hue();
        int v;
        case ($urandom_range(9))
            0: v = $urandom_range(0, 32767);
            1, 2: begin
                v = $urandom_range(0, 6) * SEXTANT + $urandom_range(0, 4) - 2;
                if (v < 0) v = 0;
            end
            default: v = $urandom_range(0, HUE_MAX);
        endcase
        return 15'(v);
    endfunction

    // random q12: mostly in range, some corner values, some any 13-bit value
    function automatic logic [12:0] rand_q12();
        int unsigned corner [7] = '{0, 1, 2047, 2048, 2049, 4095, 4096};
        case ($urandom_range(9))
            0: return 13'($urandom_range(0, 8191));
            1: return 13'(corner[$urandom_range(0, 6)]);
            default: return 13'($urandom_range(0, Q12_ONE));
        endcase
    endfunction

    // offer one beat, idling first at the current rate
    task automatic send_beat(input logic [14:0] h, input logic [12:0] s,
                             input logic [12:0] l);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.hue        <= h;
        pix_in.saturation <= s;
        pix_in.lightness  <= l;
        do @(posedge clk); while (!pix_in.ready);
    endtask

    // stop offering and wait for every colour to come out
    task automatic drain();
        pix_in.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_beat(rand_hue(), rand_q12(), rand_q12());
    endtask

    initial begin
        int idle_set  [4] = '{0, 88, 0, 19};
        int stall_set [4] = '{0, 0, 88, 19};
        rst_n             = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        hold_req          = 0;
        pix_in.valid      = 1'b0;
        pix_in.hue        = '0;
        pix_in.saturation = '0;
        pix_in.lightness  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats
        for (int i = 0; i < DIR_N; i++) begin
            send_beat(15'(dir_hue[i]), 13'(dir_sat[i]), 13'(dir_lit[i]));
        end
        drain();

        // random beats under each idle and stall mix
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct <= stall_set[p];
            send_random(PHASE_BEATS);
            drain();
        end

        // long output hold-off while input keeps coming
        idle_pct  = 0;
        stall_pct <= 0;
        hold_req  <= hold_req + 1;
        send_random(HOLD_BEATS);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d hsl beats in and %0d rgb565 beats out", beats_in, beats_out);
        $display("phases: directed corners, four idle/stall mixes, long output hold-off");
        if (fail_cnt == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/hsl_pkg.sv
hdl/hsl_if.sv
hdl/hsl_front.sv
hdl/hsl_queue.sv
hdl/hsl_back.sv
hdl/hsl_to_rgb565.sv
sim/hsl_to_rgb565_chk.sv
sim/tb.sv
